[rtl/core/clkm_pkg.sv]
// Shared types, token codes and keyword tables for the command lexer.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package clkm_pkg;

  localparam int KwCount  = 15;
  localparam int KwMaxLen = 8;

  // Token codes carried on token_kind.
  localparam logic [4:0] TK_WORD_TEXT = 5'd0;
  localparam logic [4:0] TK_STRING    = 5'd1;
  localparam logic [4:0] TK_KW_BASE   = 5'd2;
  localparam logic [4:0] TK_KW_LAST   = 5'd16;
  localparam logic [4:0] TK_BANG      = 5'd17;
  localparam logic [4:0] TK_LT        = 5'd18;
  localparam logic [4:0] TK_GT        = 5'd19;
  localparam logic [4:0] TK_HYPHEN    = 5'd20;
  localparam logic [4:0] TK_EOL       = 5'd21;

  // Character codes.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_HYPHEN  = 8'h2D;

  localparam logic [3:0] LEN_SAT = 4'd8;

  localparam logic [7:0] KW_TEXT [KwCount][KwMaxLen] = '{
    '{"l", "i", "s", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "u", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"o", "p", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "l", "o", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"l", "e", "a", "v", "e", 8'h00, 8'h00, 8'h00},
    '{"q", "u", "i", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"h", "e", "l", "p", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "o", "s", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "e", "l", "e", "t", "e", 8'h00, 8'h00},
    '{"h", "e", "a", "d", "e", "r", 8'h00, 8'h00},
    '{"v", "e", "r", "b", "o", "s", "e", 8'h00},
    '{"o", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"o", "f", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] KW_LEN [KwCount] = '{
    4'd4, 4'd3, 4'd4, 4'd5, 4'd5, 4'd4, 4'd4, 4'd3,
    4'd3, 4'd4, 4'd6, 4'd6, 4'd7, 4'd2, 4'd3
  };

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One queue entry: a first result, plus an end-of-line result when two is set.
  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] text;
    logic       two;
  } clkm_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } clkm_qstat_t;

  // Keywords that still match when byte c lands at position pos.
  function automatic logic [KwCount-1:0] kw_match(input logic [3:0] pos, input logic [7:0] c);
    logic [KwCount-1:0] m;
    m = '0;
    for (int k = 0; k < KwCount; k++) begin
      if (pos < KW_LEN[k] && KW_TEXT[k][pos[2:0]] == c) begin
        m[k] = 1'b1;
      end
    end
    return m;
  endfunction

  // Lowest-numbered live keyword of matching length, else plain string.
  function automatic logic [4:0] kw_classify(input logic [KwCount-1:0] alive,
                                             input logic [3:0] len);
    logic [4:0] kind;
    kind = TK_STRING;
    for (int k = KwCount - 1; k >= 0; k--) begin
      if (alive[k] && KW_LEN[k] == len) begin
        kind = TK_KW_BASE + 5'(k);
      end
    end
    return kind;
  endfunction

endpackage

[rtl/core/clkm_front.sv]
// Front end of the command lexer: accept bytes, track lexer state, classify words.
// Depends on clkm_pkg; pushes entries into clkm_queue.
`timescale 1ns / 1ps

module clkm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [7:0]           char_in_i,
  input  clkm_pkg::clkm_qstat_t qstat_i,
  output logic                 accept_o,
  output logic                 push_o,
  output clkm_pkg::clkm_entry_t entry_o
);

  typedef enum logic [1:0] {
    ModeIdle,
    ModeWord,
    ModeComment
  } mode_e;

  mode_e                          mode_q, mode_d;
  logic [3:0]                     len_q, len_d;
  logic [clkm_pkg::KwCount-1:0]   alive_q, alive_d;

  logic c_eol;
  logic c_space;
  logic c_hash;

  assign accept_o = in_valid_i && !qstat_i.full;
  assign c_eol    = (char_in_i == clkm_pkg::CH_NUL) || (char_in_i == clkm_pkg::CH_NEWLINE);
  assign c_space  = (char_in_i == clkm_pkg::CH_SPACE);
  assign c_hash   = (char_in_i == clkm_pkg::CH_HASH);

  always_comb begin
    mode_d       = mode_q;
    len_d        = len_q;
    alive_d      = alive_q;
    push_o       = 1'b0;
    entry_o.kind = clkm_pkg::TK_WORD_TEXT;
    entry_o.text = char_in_i;
    entry_o.two  = 1'b0;
    case (mode_q)
      ModeWord: begin
        if (c_space || c_hash || c_eol) begin
          push_o       = accept_o;
          entry_o.kind = clkm_pkg::kw_classify(alive_q, len_q);
          entry_o.text = '0;
          entry_o.two  = c_eol;
          len_d        = '0;
          alive_d      = '1;
          mode_d       = c_hash ? ModeComment : ModeIdle;
        end else begin
          push_o  = accept_o;
          alive_d = alive_q & clkm_pkg::kw_match(len_q, char_in_i);
          len_d   = (len_q < clkm_pkg::LEN_SAT) ? len_q + 4'd1 : len_q;
        end
      end
      ModeComment: begin
        if (c_eol) begin
          push_o       = accept_o;
          entry_o.kind = clkm_pkg::TK_EOL;
          entry_o.text = '0;
          mode_d       = ModeIdle;
        end
      end
      default: begin
        mode_d = ModeIdle;
        if (c_space) begin
          push_o = 1'b0;
        end else if (c_hash) begin
          mode_d = ModeComment;
        end else if (char_in_i == clkm_pkg::CH_BANG) begin
          push_o       = accept_o;
          entry_o.kind = clkm_pkg::TK_BANG;
        end else if (char_in_i == clkm_pkg::CH_LT) begin
          push_o       = accept_o;
          entry_o.kind = clkm_pkg::TK_LT;
        end else if (char_in_i == clkm_pkg::CH_GT) begin
          push_o       = accept_o;
          entry_o.kind = clkm_pkg::TK_GT;
        end else if (char_in_i == clkm_pkg::CH_HYPHEN) begin
          push_o       = accept_o;
          entry_o.kind = clkm_pkg::TK_HYPHEN;
        end else if (c_eol) begin
          push_o       = accept_o;
          entry_o.kind = clkm_pkg::TK_EOL;
          entry_o.text = '0;
        end else begin
          // First byte of a word: match from position zero with all keywords live.
          push_o  = accept_o;
          mode_d  = ModeWord;
          alive_d = clkm_pkg::kw_match(4'd0, char_in_i);
          len_d   = 4'd1;
        end
      end
    endcase
  end

  // Advance the lexer state only on an accepted byte; hold it otherwise.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      len_q   <= '0;
      alive_q <= '1;
    end else if (accept_o) begin
      mode_q  <= mode_d;
      len_q   <= len_d;
      alive_q <= alive_d;
    end
  end

endmodule

[rtl/core/clkm_queue.sv]
// Short entry queue between the lexer front end and the result back end.
// Depends on clkm_pkg for the entry type and depth.
`timescale 1ns / 1ps

module clkm_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  clkm_pkg::clkm_entry_t push_entry_i,
  input  logic                  pop_i,
  output clkm_pkg::clkm_entry_t head_o,
  output clkm_pkg::clkm_qstat_t qstat_o
);

  clkm_pkg::clkm_entry_t        mem_q [clkm_pkg::QDepth];
  logic [clkm_pkg::QAw-1:0]     wr_ptr_q;
  logic [clkm_pkg::QAw-1:0]     rd_ptr_q;
  logic [clkm_pkg::QCntW-1:0]   cnt_q;

  assign head_o        = mem_q[rd_ptr_q];
  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.full  = (cnt_q == clkm_pkg::QCntW'(clkm_pkg::QDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

[rtl/core/clkm_back.sv]
// Back end of the command lexer: expand queue entries into result words.
// Depends on clkm_pkg; drains clkm_queue into the output register.
`timescale 1ns / 1ps

module clkm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clkm_pkg::clkm_entry_t head_i,
  input  clkm_pkg::clkm_qstat_t qstat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [4:0]            token_kind_o,
  output logic [7:0]            text_byte_o,
  output logic                  last_of_run_o
);

  logic       out_valid_q;
  logic       pend_eol_q;
  logic [4:0] kind_q;
  logic [7:0] text_q;
  logic       last_q;
  logic       load;

  assign load  = !out_valid_q || !out_stall_i;
  assign pop_o = load && !pend_eol_q && !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_eol_q  <= 1'b0;
    end else if (load) begin
      if (pend_eol_q) begin
        out_valid_q <= 1'b1;
        pend_eol_q  <= 1'b0;
      end else begin
        out_valid_q <= !qstat_i.empty;
        pend_eol_q  <= !qstat_i.empty && head_i.two;
      end
    end
  end

  // Payload: the second word of a two-word entry is always end of line.
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_eol_q) begin
        kind_q <= clkm_pkg::TK_EOL;
        text_q <= '0;
        last_q <= 1'b1;
      end else begin
        kind_q <= head_i.kind;
        text_q <= head_i.text;
        last_q <= !head_i.two;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = kind_q;
  assign text_byte_o   = text_q;
  assign last_of_run_o = last_q;

endmodule

[rtl/core/command_lexer_keyword_match.sv]
// Command lexer with keyword match: one command-line byte in per cycle, tokens out.
// An accepted byte's first result word passes the entry queue, then the output register.
// Throughput: one byte per cycle; one result word leaves per cycle while out_stall_i is low,
// so a byte that ends a word at end of line yields two words; input stalls on a full queue.
// Reset (rst_ni low, async): between tokens, empty queue, no output word pending.
// Depends on clkm_pkg, clkm_front, clkm_queue and clkm_back.
`timescale 1ns / 1ps

module command_lexer_keyword_match (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] token_kind_o,
  output logic [7:0] text_byte_o,
  output logic       last_of_run_o
);

  clkm_pkg::clkm_qstat_t qstat;
  clkm_pkg::clkm_entry_t push_entry;
  clkm_pkg::clkm_entry_t head;
  logic                  accept;
  logic                  push;
  logic                  pop;

  // Stall the input only when the entry queue is full; the front end then
  // holds its lexer state until a slot frees up.
  assign in_stall_o = qstat.full;

  // Front end: byte classification, word tracking, keyword mask.
  clkm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .char_in_i  (char_in_i),
    .qstat_i    (qstat),
    .accept_o   (accept),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Queue decouples the byte stream from output back-pressure.
  clkm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .qstat_o      (qstat)
  );

  // Back end: one result word per cycle into the output register unless the output stalls.
  clkm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .text_byte_o   (text_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  // Never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && qstat.full))
    else $error("entry pushed into full queue");

  // A push only happens on an accepted byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> accept)
    else $error("entry pushed without accepted byte");

  // A word that is not last of its run is followed at once by end of line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && !out_stall_i && !last_of_run_o) |=>
                   (out_valid_o && token_kind_o == clkm_pkg::TK_EOL && last_of_run_o))
    else $error("end of line missing after classification");

  // Only a word classification can precede end of line within one run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && !last_of_run_o) |->
                   (token_kind_o >= clkm_pkg::TK_STRING &&
                    token_kind_o <= clkm_pkg::TK_KW_LAST))
    else $error("unexpected token kind before end of line");

endmodule

[verif/command_lexer_keyword_match_tb.sv]
// Self-checking testbench for command_lexer_keyword_match: drives command-line bytes,
// predicts every token word and compares each one field by field as it leaves the block.
// Depends on clkm_pkg for token codes, character codes and the keyword table.
`timescale 1ns / 1ps

module command_lexer_keyword_match_tb;

  localparam int TimeoutNs    = 2_000_000;
  localparam int ItemCount    = 1400;   // bytes to send in total
  localparam int HoldOffAt    = 400;    // byte count where the long output hold-off starts
  localparam int HoldOffLen   = 120;    // cycles of that hold-off
  localparam int DrainAt      = 900;    // byte count where the sender waits for a full drain
  localparam int DrainLimit   = 20_000;
  localparam int LatencyTail  = 8;
  localparam int MaxReports   = 20;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_COMMENT = 2'd2
  } lex_mode_e;

  // One result word as the block presents it.
  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] text;
    logic       last;
  } token_t;

  // One row of directed stimulus; typed rows carry their single expected token
  // (or none when n is zero), the rest are left to the predictor.
  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    logic [1:0] n;
    logic [4:0] kind;
    logic [7:0] text;
  } dir_row_t;

  localparam int DirRows = 24;
  localparam dir_row_t DirTable [DirRows] = '{
    '{clkm_pkg::CH_BANG, 1'b1, 2'd1, clkm_pkg::TK_BANG, clkm_pkg::CH_BANG}, // marks
    '{clkm_pkg::CH_LT, 1'b1, 2'd1, clkm_pkg::TK_LT, clkm_pkg::CH_LT},
    '{clkm_pkg::CH_GT, 1'b1, 2'd1, clkm_pkg::TK_GT, clkm_pkg::CH_GT},
    '{clkm_pkg::CH_HYPHEN, 1'b1, 2'd1, clkm_pkg::TK_HYPHEN, clkm_pkg::CH_HYPHEN},
    '{clkm_pkg::CH_NEWLINE, 1'b1, 2'd1, clkm_pkg::TK_EOL, 8'h00},   // empty line ends
    '{clkm_pkg::CH_NUL, 1'b1, 2'd1, clkm_pkg::TK_EOL, 8'h00},
    '{clkm_pkg::CH_SPACE, 1'b1, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00}, // skipped space
    '{clkm_pkg::CH_HASH, 1'b1, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00},  // comment from idle
    '{clkm_pkg::CH_BANG, 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00},  // swallowed
    '{clkm_pkg::CH_NEWLINE, 1'b1, 2'd1, clkm_pkg::TK_EOL, 8'h00},
    '{8'h61, 1'b1, 2'd1, clkm_pkg::TK_WORD_TEXT, 8'h61},              // "a" opens a word
    '{clkm_pkg::CH_BANG, 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00},  // mark inside a word
    '{clkm_pkg::CH_HASH, 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00},  // word ended by '#'
    '{clkm_pkg::CH_NEWLINE, 1'b1, 2'd1, clkm_pkg::TK_EOL, 8'h00},
    '{8'h6F, 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00},              // "on" then zero
    '{8'h6E, 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00},
    '{clkm_pkg::CH_NUL, 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00},
    '{8'h80, 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00},              // high bytes as text
    '{8'hFF, 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00},
    '{clkm_pkg::CH_SPACE, 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00},
    '{8'h6F, 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00},              // "off" then newline
    '{8'h66, 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00},
    '{8'h66, 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00},
    '{clkm_pkg::CH_NEWLINE, 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_in_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [4:0] token_kind_o;
  logic [7:0] text_byte_o;
  logic       last_of_run_o;

  // Predictor state: mirrors the lexer mode, the text length and the live keyword mask.
  lex_mode_e                    lex_mode;
  logic [3:0]                   text_len;
  logic [clkm_pkg::KwCount-1:0] kw_alive;

  token_t      tokens_due[$];     // expected result words, oldest first
  logic [7:0]  line_q[$];         // bytes of the command line being sent
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned busy_bytes = 0;
  int unsigned tokens_checked = 0;
  int unsigned burst_left = 0;
  logic [21:0] kinds_seen = '0;
  logic        hold_off_req = 1'b0;

  command_lexer_keyword_match dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_in_i     (char_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .text_byte_o   (text_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void flag_error(input string what, input int unsigned want,
                                     input int unsigned got);
    if (errors < MaxReports) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
    errors++;
  endfunction

  // Advance the keyword mask by one text byte and count the length up to saturation.
  function automatic void take_text_byte(input logic [7:0] c);
    for (int k = 0; k < clkm_pkg::KwCount; k++) begin
      if (!(text_len < clkm_pkg::KW_LEN[k] && clkm_pkg::KW_TEXT[k][text_len[2:0]] == c)) begin
        kw_alive[k] = 1'b0;
      end
    end
    if (text_len < clkm_pkg::LEN_SAT) begin
      text_len++;
    end
  endfunction

  // Work out the result words for one accepted byte; returns how many there are.
  function automatic int unsigned lex_step(input logic [7:0] c, output token_t r0,
                                           output token_t r1);
    logic       eol;
    logic       found;
    logic [4:0] kind;
    eol = (c == clkm_pkg::CH_NEWLINE || c == clkm_pkg::CH_NUL);
    r0 = '0;
    r1 = '0;
    if (lex_mode == MODE_WORD) begin
      if (c == clkm_pkg::CH_SPACE || c == clkm_pkg::CH_HASH || eol) begin
        // Classify: the first live keyword whose length matches, else plain string.
        kind = clkm_pkg::TK_STRING;
        found = 1'b0;
        for (int k = 0; k < clkm_pkg::KwCount; k++) begin
          if (!found && kw_alive[k] && clkm_pkg::KW_LEN[k] == text_len) begin
            kind = clkm_pkg::TK_KW_BASE + 5'(k);
            found = 1'b1;
          end
        end
        text_len = '0;
        kw_alive = '1;
        if (eol) begin
          lex_mode = MODE_IDLE;
          r0 = '{kind, 8'h00, 1'b0};
          r1 = '{clkm_pkg::TK_EOL, 8'h00, 1'b1};
          return 2;
        end
        lex_mode = (c == clkm_pkg::CH_HASH) ? MODE_COMMENT : MODE_IDLE;
        r0 = '{kind, 8'h00, 1'b1};
        return 1;
      end
      take_text_byte(c);
      r0 = '{clkm_pkg::TK_WORD_TEXT, c, 1'b1};
      return 1;
    end
    if (lex_mode == MODE_COMMENT) begin
      if (eol) begin
        lex_mode = MODE_IDLE;
        r0 = '{clkm_pkg::TK_EOL, 8'h00, 1'b1};
        return 1;
      end
      return 0;
    end
    lex_mode = MODE_IDLE;
    case (c)
      clkm_pkg::CH_SPACE: return 0;
      clkm_pkg::CH_HASH: begin
        lex_mode = MODE_COMMENT;
        return 0;
      end
      clkm_pkg::CH_BANG:   r0 = '{clkm_pkg::TK_BANG, c, 1'b1};
      clkm_pkg::CH_LT:     r0 = '{clkm_pkg::TK_LT, c, 1'b1};
      clkm_pkg::CH_GT:     r0 = '{clkm_pkg::TK_GT, c, 1'b1};
      clkm_pkg::CH_HYPHEN: r0 = '{clkm_pkg::TK_HYPHEN, c, 1'b1};
      clkm_pkg::CH_NEWLINE, clkm_pkg::CH_NUL: r0 = '{clkm_pkg::TK_EOL, 8'h00, 1'b1};
      default: begin
        lex_mode = MODE_WORD;
        text_len = '0;
        kw_alive = '1;
        take_text_byte(c);
        r0 = '{clkm_pkg::TK_WORD_TEXT, c, 1'b1};
      end
    endcase
    return 1;
  endfunction

  // Any byte that keeps a text token going: never space, '#', newline or zero.
  // Lean on lowercase letters so partial keyword matches come up often.
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 7) begin
      return 8'($urandom_range(8'h61, 8'h7A));
    end
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == clkm_pkg::CH_SPACE || c == clkm_pkg::CH_HASH ||
               c == clkm_pkg::CH_NEWLINE);
    return c;
  endfunction

  // Build one command line into line_q: mostly keywords and near misses separated by
  // spaces, with marks, comments and long text mixed in; now and then pure noise.
  task automatic build_line();
    int unsigned n_tok;
    int unsigned pick;
    int unsigned k;
    int unsigned len;
    int unsigned pos;
    int unsigned sep;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n_tok = $urandom_range(1, 5);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, clkm_pkg::KwCount - 1);
      len = clkm_pkg::KW_LEN[k];
      if (pick < 45) begin
        for (int i = 0; i < len; i++) line_q.push_back(clkm_pkg::KW_TEXT[k][i]);
      end else if (pick < 55) begin
        for (int i = 0; i < len - 1; i++) line_q.push_back(clkm_pkg::KW_TEXT[k][i]);
        if (len == 2) line_q.push_back(text_char());
      end else if (pick < 62) begin
        for (int i = 0; i < len; i++) line_q.push_back(clkm_pkg::KW_TEXT[k][i]);
        line_q.push_back(text_char());
      end else if (pick < 68) begin
        pos = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) begin
          line_q.push_back(i == pos ? 8'($urandom_range(8'h61, 8'h7A)) :
                                      clkm_pkg::KW_TEXT[k][i]);
        end
      end else if (pick < 74) begin
        repeat ($urandom_range(7, 12)) line_q.push_back(text_char());
      end else if (pick < 84) begin
        repeat ($urandom_range(1, 4)) line_q.push_back(text_char());
      end else begin
        case ($urandom_range(0, 3))
          0: line_q.push_back(clkm_pkg::CH_BANG);
          1: line_q.push_back(clkm_pkg::CH_LT);
          2: line_q.push_back(clkm_pkg::CH_GT);
          default: line_q.push_back(clkm_pkg::CH_HYPHEN);
        endcase
      end
      // Separator: usually one space, sometimes two, sometimes none so that a
      // text token runs straight into a mark or into the line end.
      sep = $urandom_range(0, 9);
      if (sep < 7) begin
        line_q.push_back(clkm_pkg::CH_SPACE);
      end else if (sep == 7) begin
        line_q.push_back(clkm_pkg::CH_SPACE);
        line_q.push_back(clkm_pkg::CH_SPACE);
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      line_q.push_back(clkm_pkg::CH_HASH);
      repeat ($urandom_range(0, 6)) begin
        line_q.push_back(8'($urandom_range(1, 255)) == clkm_pkg::CH_NEWLINE ?
                         clkm_pkg::CH_SPACE : 8'($urandom_range(1, 255)));
      end
    end
    line_q.push_back($urandom_range(0, 3) == 0 ? clkm_pkg::CH_NUL : clkm_pkg::CH_NEWLINE);
  endtask

  // Offer one byte: open a new burst after a random gap when the current one is used
  // up, hold the byte until accepted, then book its expected result words.
  task automatic send_byte(input dir_row_t row);
    int unsigned n;
    token_t      r0;
    token_t      r1;
    if (burst_left == 0) begin
      // One burst in four runs without a gap in front of it.
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        char_in_i  <= 8'($urandom_range(0, 255));
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    char_in_i  <= row.ch;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    n = lex_step(row.ch, r0, r1);
    if (row.typed) begin
      n  = row.n;
      r0 = '{row.kind, row.text, 1'b1};
    end
    if (n > 0) begin
      tokens_due.push_back(r0);
      busy_bytes++;
    end
    if (n > 1) begin
      tokens_due.push_back(r1);
    end
    bytes_sent++;
  endtask

  // Drop valid and hold it low until every expected word has come out or the drain limit runs out.
  task automatic drain_tokens();
    int unsigned waited;
    waited = 0;
    do begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      waited++;
    end while (tokens_due.size() != 0 && waited < DrainLimit);
  endtask

  // Receiver: stall in phases of random length and density, with phases of no stall,
  // and once take a long hold-off when the sender asks for it so the block backs up.
  initial begin : receiver
    int unsigned span;
    int unsigned stall_pct;
    int unsigned held;
    span = 0;
    stall_pct = 0;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        held++;
        if (held == HoldOffLen) begin
          hold_off_req = 1'b0;
        end
      end else begin
        if (span == 0) begin
          span = $urandom_range(4, 64);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        span--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Checker: compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin : check_tokens
    token_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tokens_due.size() == 0) begin
        if (errors < MaxReports) begin
          $display("%0t ns: unexpected word: expected none, actual kind %0d text %0d last %0d",
                   $time, token_kind_o, text_byte_o, last_of_run_o);
        end
        errors++;
      end else begin
        want = tokens_due.pop_front();
        if (token_kind_o !== want.kind) flag_error("token_kind", want.kind, token_kind_o);
        if (text_byte_o !== want.text) flag_error("text_byte", want.text, text_byte_o);
        if (last_of_run_o !== want.last) flag_error("last_of_run", want.last, last_of_run_o);
        if (want.kind <= clkm_pkg::TK_EOL) kinds_seen[want.kind] = 1'b1;
        tokens_checked++;
      end
    end
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic hold_done;
    logic drain_done;
    hold_done = 1'b0;
    drain_done = 1'b0;
    lex_mode = MODE_IDLE;
    text_len = '0;
    kw_alive = '1;

    // Hold reset low, then release it away from the rising edge.
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: walk the table.
    for (int i = 0; i < DirRows; i++) begin
      send_byte(DirTable[i]);
    end

    // Random part: whole lines until the byte budget is used up.
    while (bytes_sent < ItemCount) begin
      if (line_q.size() == 0) build_line();
      send_byte('{line_q.pop_front(), 1'b0, 2'd0, clkm_pkg::TK_WORD_TEXT, 8'h00});
      if (!hold_done && bytes_sent >= HoldOffAt) begin
        hold_off_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && bytes_sent >= DrainAt) begin
        drain_tokens();
        drain_done = 1'b1;
      end
    end

    // Wind down: let the last words out, then wait out the LatencyTail tail before the final check.
    drain_tokens();
    repeat (LatencyTail) @(posedge clk_i);
    if (tokens_due.size() != 0) begin
      $display("%0t ns: %0d expected words never came out, first kind %0d text %0d",
               $time, tokens_due.size(), tokens_due[0].kind, tokens_due[0].text);
      errors += tokens_due.size();
    end

    $display("Sent %0d bytes, %0d of them causing tokens; checked %0d result words.",
             bytes_sent, busy_bytes, tokens_checked);
    $display("Saw %0d of 22 token kinds, with a long output hold-off and a full drain pause.",
             $countones(kinds_seen));
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
